@@ src/l2h_pkg.sv @@
// Shared types, constants and a helper function of the lookup2 byte-stream hash.
package l2h_pkg;

  localparam logic [31:0] GOLDEN    = 32'h9e37_79b9;
  localparam int          BLOCK_LEN = 12;
  localparam logic [3:0]  BLOCK_END = 4'(BLOCK_LEN - 1);
  localparam int          MIX_STEPS = 9;
  localparam logic [3:0]  MIX_LAST  = 4'(MIX_STEPS - 1);

  // One unit of work for the mixing engine: either a complete block, a key's
  // closing tail, or both when the last byte of a key completes a block.
  typedef struct packed {
    logic        first;
    logic        do_block;
    logic        do_final;
    logic [31:0] len;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } l2h_job_t;

  typedef enum logic {
    BK_IDLE,
    BK_MIX
  } l2h_bk_state_t;

  // Shift amount used by each of the nine subtract/shift/xor lines of mix().
  function automatic logic [4:0] mix_shift(input logic [3:0] step);
    logic [4:0] sh;
    case (step)
      4'd0:    sh = 5'd13;
      4'd1:    sh = 5'd8;
      4'd2:    sh = 5'd13;
      4'd3:    sh = 5'd12;
      4'd4:    sh = 5'd16;
      4'd5:    sh = 5'd5;
      4'd6:    sh = 5'd3;
      4'd7:    sh = 5'd10;
      4'd8:    sh = 5'd15;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

endpackage

@@ src/l2h_front.sv @@
// Front end: packs key bytes into 12-byte blocks and issues block and tail jobs.
module l2h_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_has_byte,
  input  logic               in_is_last,
  output logic               job_push,
  output l2h_pkg::l2h_job_t  job_data,
  input  logic               job_full
);

  logic [7:0]  bytes_r [l2h_pkg::BLOCK_LEN];
  logic [3:0]  fill_r, fill_nxt;
  logic [31:0] len_r, len_nxt;
  logic        open_r, open_nxt;

  logic        accept;
  logic        blk_full;
  logic [3:0]  fill_new;
  logic [31:0] len_new;
  logic [7:0]  blk [l2h_pkg::BLOCK_LEN];
  logic [7:0]  m [l2h_pkg::BLOCK_LEN];

  assign in_stall = job_full;
  assign accept   = in_valid && !in_stall;
  assign blk_full = in_has_byte && (fill_r == l2h_pkg::BLOCK_END);
  assign fill_new = fill_r + {3'b000, in_has_byte};
  assign len_new  = len_r + {31'b0, in_has_byte};

  always_comb begin
    for (int i = 0; i < l2h_pkg::BLOCK_LEN; i++) begin
      blk[i] = (in_has_byte && (fill_r == 4'(i))) ? in_data_byte : bytes_r[i];
      // Bytes past the fill level are stale from an earlier block.
      m[i]   = (4'(i) < fill_new) ? blk[i] : 8'h00;
    end
  end

  always_comb begin
    job_data.first    = !open_r;
    job_data.do_block = blk_full;
    job_data.do_final = in_is_last;
    job_data.len      = len_new;
    job_data.w0       = {m[3], m[2], m[1], m[0]};
    job_data.w1       = {m[7], m[6], m[5], m[4]};
    // The tail's third word sits one byte higher than a full block's.
    job_data.w2       = blk_full ? {m[11], m[10], m[9], m[8]}
                                 : {m[10], m[9], m[8], 8'h00};
  end

  assign job_push = accept && (in_is_last || blk_full);

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    open_nxt = open_r;
    if (accept && (in_has_byte || in_is_last)) begin
      fill_nxt = (blk_full || in_is_last) ? 4'd0 : fill_new;
      len_nxt  = in_is_last ? 32'd0 : len_new;
    end
    // A key stays open from its first job to the engine until its closing job.
    if (job_push) begin
      open_nxt = !in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_has_byte) begin
      bytes_r[fill_r] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 4'd0;
      len_r  <= 32'd0;
      open_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

@@ src/l2h_fifo.sv @@
// Two-entry job queue between the front end and the mixing engine.
module l2h_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  l2h_pkg::l2h_job_t  push_data,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop,
  output l2h_pkg::l2h_job_t  pop_data
);

  l2h_pkg::l2h_job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/l2h_back.sv @@
// Mixing engine: adds job words into a, b, c; runs mix() one line per cycle unless held.
module l2h_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        seed,
  input  logic               job_valid,
  output logic               job_pop,
  input  l2h_pkg::l2h_job_t  job_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_hash_value
);

  l2h_pkg::l2h_bk_state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        again_r, again_nxt;
  logic        fin_r, fin_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] hash_r, hash_nxt;

  logic        pop_rdy;
  logic        out_free;
  logic        last_step;
  logic        emit;
  logic        hold;
  logic [4:0]  sh;
  logic [31:0] a_m, b_m, c_m;
  logic [31:0] base_a, base_b, base_c;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = (step_r == l2h_pkg::MIX_LAST);
  // A finished hash waits in the last mix step while the output is occupied.
  assign hold      = (state_r == l2h_pkg::BK_MIX) && last_step && !again_r && fin_r
                     && !out_free;
  assign emit      = (state_r == l2h_pkg::BK_MIX) && last_step && !again_r && fin_r
                     && out_free;
  assign job_pop   = pop_rdy && job_valid;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      l2h_pkg::BK_IDLE: begin
        if (job_valid) begin
          state_nxt = l2h_pkg::BK_MIX;
        end
      end
      l2h_pkg::BK_MIX: begin
        if (last_step && !again_r && !hold) begin
          state_nxt = l2h_pkg::BK_IDLE;
        end
      end
      default: state_nxt = l2h_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    unique case (state_r)
      l2h_pkg::BK_IDLE: pop_rdy = 1'b1;
      l2h_pkg::BK_MIX:  pop_rdy = 1'b0;
      default:          pop_rdy = 1'b0;
    endcase
  end

  // One line of mix(): the target register rotates through a, b, c.
  always_comb begin
    sh  = l2h_pkg::mix_shift(step_r);
    a_m = a_r;
    b_m = b_r;
    c_m = c_r;
    case (step_r) inside
      4'd0, 4'd3, 4'd6: a_m = (a_r - b_r - c_r) ^ (c_r >> sh);
      4'd1, 4'd4, 4'd7: b_m = (b_r - c_r - a_r) ^ (a_r << sh);
      default:          c_m = (c_r - a_r - b_r) ^ (b_r >> sh);
    endcase
  end

  always_comb begin
    base_a = job_data.first ? l2h_pkg::GOLDEN : a_r;
    base_b = job_data.first ? l2h_pkg::GOLDEN : b_r;
    base_c = job_data.first ? seed : c_r;
  end

  always_comb begin
    step_nxt      = step_r;
    again_nxt     = again_r;
    fin_nxt       = fin_r;
    len_nxt       = len_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (job_pop) begin
      a_nxt     = base_a + job_data.w0;
      b_nxt     = base_b + job_data.w1;
      c_nxt     = base_c + job_data.w2 + (job_data.do_block ? 32'd0 : job_data.len);
      step_nxt  = 4'd0;
      again_nxt = job_data.do_block && job_data.do_final;
      fin_nxt   = job_data.do_final;
      len_nxt   = job_data.len;
    end else if ((state_r == l2h_pkg::BK_MIX) && !hold) begin
      a_nxt    = a_m;
      b_nxt    = b_m;
      c_nxt    = c_m;
      step_nxt = last_step ? 4'd0 : step_r + 4'd1;
      if (last_step && again_r) begin
        // Block closed the key: the tail phase adds only the length.
        c_nxt     = c_m + len_r;
        again_nxt = 1'b0;
      end
      if (emit) begin
        hash_nxt      = c_m;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    hash_r <= hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= l2h_pkg::BK_IDLE;
      step_r      <= 4'd0;
      again_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      again_r     <= again_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == l2h_pkg::BK_MIX) |-> (step_r <= l2h_pkg::MIX_LAST))
    else $error("mix step counter out of range");

  a_pop_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == l2h_pkg::BK_MIX) && (step_r == 4'd0))
    else $error("popped job did not start a mix at its first line");

  a_again_final: assert property (@(posedge clk) disable iff (!rst_n)
    again_r |-> fin_r)
    else $error("second mix pending on a job that does not close a key");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == l2h_pkg::BK_IDLE) |-> !again_r)
    else $error("engine went idle with a tail mix still pending");
`endif

endmodule

@@ src/lookup2_byte_stream_hash.sv @@
// Top level of the streaming lookup2 32-bit hash.
// Key bytes arrive one per transfer and are accepted at one per cycle while the
// job queue is not full; every twelfth byte sends a block to a two-entry queue,
// and the mixing engine takes the block in, adding it to a, b, c, then runs the
// nine mix lines one after another, so long keys stream at full rate. Once the
// item marked last is taken, out_valid rises after the engine's mix of the
// tail, or after two mixes when that byte also completes a block, because the
// engine then runs a second mix right after the first. The engine's work per
// key sets how fast very short keys can follow one another. The seed register is
// loaded into c at the start of each key; write it only while the block is idle.
module lookup2_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  logic [31:0] seed_r, seed_nxt;

  logic              push, full, q_valid, pop;
  l2h_pkg::l2h_job_t push_job, pop_job;

  assign seed_nxt = cfg_wr_en ? cfg_wr_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  l2h_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_is_last   (in_is_last),
    .job_push     (push),
    .job_data     (push_job),
    .job_full     (full)
  );

  l2h_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .full      (full),
    .pop_valid (q_valid),
    .pop       (pop),
    .pop_data  (pop_job)
  );

  l2h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .job_valid      (q_valid),
    .job_pop        (pop),
    .job_data       (pop_job),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the streaming lookup2 byte hash, with its own hash predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PERCENT  = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } key_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_regs_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [31:0] cfg_wr_data    = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte   = '0;
  logic        in_has_byte    = 1'b0;
  logic        in_is_last     = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [31:0] out_hash_value;

  key_item_t   pending_items[$];
  logic [31:0] expected_hashes[$];
  int          queued_count   = 0;
  int          accepted_count = 0;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  logic        calm;

  // Predictor state.
  logic [31:0] hash_seed = '0;
  logic [31:0] key_a;
  logic [31:0] key_b;
  logic [31:0] key_c;
  logic [31:0] key_len;
  logic [7:0]  block_store[l2h_pkg::BLOCK_LEN];
  int          block_fill = 0;
  bit          key_open   = 1'b0;

  lookup2_byte_stream_hash u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_has_byte   (in_has_byte),
    .in_is_last    (in_is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hash_value(out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Both sides run without idling for a stretch in the middle of the run.
  assign calm = (accepted_count >= 200) && (accepted_count < 360);

  function automatic mix_regs_t lookup2_mix(mix_regs_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = s.a;
    b = s.b;
    c = s.c;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return '{a: a, b: b, c: c};
  endfunction

  // Folds one accepted item into the running key and queues the hash when the key ends.
  function automatic void hash_absorb(logic [7:0] data_byte, logic has_byte, logic is_last);
    mix_regs_t s;
    if (!has_byte && !is_last) return;
    if (!key_open) begin
      key_a      = l2h_pkg::GOLDEN;
      key_b      = l2h_pkg::GOLDEN;
      key_c      = hash_seed;
      key_len    = '0;
      block_fill = 0;
      key_open   = 1'b1;
    end
    if (has_byte) begin
      block_store[block_fill] = data_byte;
      block_fill++;
      key_len++;
      if (block_fill == l2h_pkg::BLOCK_LEN) begin
        s.a = key_a + {block_store[3], block_store[2], block_store[1], block_store[0]};
        s.b = key_b + {block_store[7], block_store[6], block_store[5], block_store[4]};
        s.c = key_c + {block_store[11], block_store[10], block_store[9], block_store[8]};
        s = lookup2_mix(s);
        key_a = s.a;
        key_b = s.b;
        key_c = s.c;
        block_fill = 0;
      end
    end
    if (is_last) begin
      s.a = key_a;
      s.b = key_b;
      s.c = key_c + key_len;
      // The low byte of c is reserved for the length, so c's tail bytes sit one byte up.
      for (int i = 0; i < block_fill; i++) begin
        if (i < 4) s.a += 32'(block_store[i]) << (8 * i);
        else if (i < 8) s.b += 32'(block_store[i]) << (8 * (i - 4));
        else s.c += 32'(block_store[i]) << (8 * (i - 7));
      end
      s = lookup2_mix(s);
      expected_hashes.push_back(s.c);
      key_open = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic push_item(input logic [7:0] data_byte, input logic has_byte,
                           input logic is_last);
    pending_items.push_back('{data_byte: data_byte, has_byte: has_byte, is_last: is_last});
    queued_count++;
  endtask

  task automatic queue_random_key();
    int len;
    bit end_alone;
    if ($urandom_range(99) < 5) push_item(8'($urandom), 1'b0, 1'b0);
    if ($urandom_range(99) < 80) len = $urandom_range(0, 26);
    else len = $urandom_range(27, 60);
    if (len == 0) begin
      push_item(8'($urandom), 1'b0, 1'b1);
      return;
    end
    end_alone = ($urandom_range(99) < 25);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 4) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, (k == len - 1) && !end_alone);
    end
    if (end_alone) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic queue_random_keys(input int budget);
    int start;
    start = queued_count;
    while (queued_count - start < budget) queue_random_key();
  endtask

  // Waits until every item has been taken and every hash has come back, then lets the
  // engine finish any block that produces no result.
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hash_seed = value;
  endtask

  initial begin : run_test
    logic [31:0] seeds[4];
    seeds[0] = 32'hffff_ffff;
    seeds[1] = $urandom;
    seeds[2] = 32'h0000_0000;
    seeds[3] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed keys under the reset seed: empty key, one-byte keys at both extremes,
    // a stray idle item, a key whose last byte completes a block, and a key ended by
    // an item that carries no byte.
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'hff, 1'b0, 1'b0);
    for (int k = 0; k < 12; k++) push_item(8'hff, 1'b1, k == 11);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'ha5, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      queue_random_keys(150);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_items
    key_item_t nxt;
    if (in_valid && !in_stall) begin
      hash_absorb(in_data_byte, in_has_byte, in_is_last);
      accepted_count++;
    end
    // A stalled transfer holds its payload; a new item is offered only once the slot frees.
    if (rst_n && (!in_valid || !in_stall)) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        nxt = pending_items.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= nxt.data_byte;
        in_has_byte  <= nxt.has_byte;
        in_is_last   <= nxt.is_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_hashes
    logic [31:0] want;
    if (out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %08h arrived with none expected", out_hash_value));
      end else begin
        want = expected_hashes.pop_front();
        if (out_hash_value !== want)
          report_mismatch($sformatf("hash_value %08h, expected %08h", out_hash_value, want));
      end
    end
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
